FILE: design/gwd_pkg.sv
`default_nettype none

package gwd_pkg;

  localparam int unsigned TimeBitsDefault = 32;
  localparam int unsigned NowWidth        = 32;
  localparam int unsigned DelayWidth      = 32;
  localparam int unsigned ModeWidth       = 3;
  localparam int unsigned AddrWidth       = 4;
  localparam int unsigned DataWidth       = 32;

  typedef enum logic [ModeWidth-1:0] {
    MODE_LOW_LEVEL  = 3'd0,
    MODE_HIGH_LEVEL = 3'd1,
    MODE_CHANGE     = 3'd2,
    MODE_RISING     = 3'd3,
    MODE_FALLING    = 3'd4
  } watch_mode_e;

  typedef enum logic [1:0] {
    REG_ENABLE       = 2'd0,
    REG_WATCH_MODE   = 2'd1,
    REG_SETTLE_DELAY = 2'd2,
    REG_START_LEVEL  = 2'd3
  } reg_index_e;

  typedef struct packed {
    logic                pin_level;
    logic [NowWidth-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic fire;
    logic stable_level;
  } out_item_t;

endpackage

`default_nettype wire

FILE: design/gpio_watch_debouncer.sv
// gpio_watch_debouncer: debounced pin watch with level and edge events.
// Input channel (in_valid_i/in_ready_o, in_item_i) carries one poll per
// transfer: the raw pin level and the current millisecond time. Output
// channel (out_valid_o/out_ready_i, out_item_o) returns exactly one result
// per poll, in order: fire and the debounced level after that poll.
// Each result is registered, in the skid register if one waits. One poll per
// cycle is sustained while the receiver takes results; the state update is
// a single compare-and-update pass ahead of the result register.
// A two-entry output buffer (result register plus skid register) lets the
// block take a poll while a result waits; in_ready_o drops only when both
// entries are full, so a stalled receiver holds back at most two results.
// Configuration goes through the APB port: enable (0x0), watch_mode (0x4),
// settle delay in ms (0x8), start_level (0xC). Writing start_level loads the
// previous and accepted levels and clears any pending change; write
// registers only while the block is idle.
// Reset clears the buffer, disables the watch, selects change mode with
// zero delay, and sets both levels low with no pending change.
`default_nettype none

module gpio_watch_debouncer
  import gwd_pkg::*;
#(
  parameter int unsigned TIME_BITS = TimeBitsDefault
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire in_item_t             in_item_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output out_item_t                 out_item_o,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [AddrWidth-1:0] paddr,
  input  wire logic [DataWidth-1:0] pwdata,
  output logic [DataWidth-1:0]      prdata,
  output logic                      pready
);

  localparam int unsigned CmpW = (TIME_BITS > DelayWidth) ? TIME_BITS : DelayWidth;

  logic                  enable_q;
  logic [ModeWidth-1:0]  mode_q;
  logic [DelayWidth-1:0] delay_q;
  logic                  start_q;

  logic                  prev_q, prev_d;
  logic                  acc_q, acc_d;
  logic [TIME_BITS-1:0]  ctime_q, ctime_d;
  logic                  pend_q, pend_d;

  logic      out_vld_q, skid_vld_q;
  out_item_t out_q, skid_q;

  logic                 push, pop, cfg_wr;
  reg_index_e           cfg_idx;
  logic                 rd, chg, pend, settle, level_hit, edge_hit, fire;
  logic [TIME_BITS-1:0] now_t, ct, elapsed;
  out_item_t            res;

  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite && pready;
  assign cfg_idx    = reg_index_e'(paddr[3:2]);
  assign in_ready_o = !skid_vld_q;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = out_vld_q && out_ready_i;

  always_comb begin
    case (cfg_idx)
      REG_ENABLE:       prdata = {{(DataWidth-1){1'b0}}, enable_q};
      REG_WATCH_MODE:   prdata = {{(DataWidth-ModeWidth){1'b0}}, mode_q};
      REG_SETTLE_DELAY: prdata = delay_q;
      REG_START_LEVEL:  prdata = {{(DataWidth-1){1'b0}}, start_q};
      default:          prdata = '0;
    endcase
  end

  // debounce update for one poll
  always_comb begin
    rd        = in_item_i.pin_level;
    now_t     = TIME_BITS'(in_item_i.now_ms);
    chg       = (prev_q != rd);
    ct        = chg ? now_t : ctime_q;
    pend      = chg || pend_q;
    elapsed   = now_t - ct;
    settle    = pend && (CmpW'(elapsed) >= CmpW'(delay_q));
    level_hit = ((mode_q == MODE_LOW_LEVEL) && !rd) || ((mode_q == MODE_HIGH_LEVEL) && rd);
    case (mode_q)
      MODE_CHANGE:  edge_hit = 1'b1;
      MODE_RISING:  edge_hit = rd;
      MODE_FALLING: edge_hit = !rd;
      default:      edge_hit = 1'b0;
    endcase

    prev_d  = prev_q;
    acc_d   = acc_q;
    ctime_d = ctime_q;
    pend_d  = pend_q;
    fire    = 1'b0;
    if (enable_q) begin
      prev_d  = rd;
      ctime_d = ct;
      pend_d  = pend;
      if (level_hit) begin
        fire = 1'b1;
      end else if (settle) begin
        pend_d = 1'b0;
        if (rd != acc_q) begin
          acc_d = rd;
          fire  = edge_hit;
        end
      end
    end
    res.fire         = fire;
    res.stable_level = acc_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      mode_q   <= MODE_CHANGE;
      delay_q  <= '0;
      start_q  <= 1'b0;
      prev_q   <= 1'b0;
      acc_q    <= 1'b0;
      ctime_q  <= '0;
      pend_q   <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_ENABLE:       enable_q <= pwdata[0];
        REG_WATCH_MODE:   mode_q   <= pwdata[ModeWidth-1:0];
        REG_SETTLE_DELAY: delay_q  <= pwdata;
        REG_START_LEVEL: begin
          start_q <= pwdata[0];
          prev_q  <= pwdata[0];
          acc_q   <= pwdata[0];
          ctime_q <= '0;
          pend_q  <= 1'b0;
        end
        default: ;
      endcase
    end else if (push) begin
      prev_q  <= prev_d;
      acc_q   <= acc_d;
      ctime_q <= ctime_d;
      pend_q  <= pend_d;
    end
  end

  // result register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= push;
      end else begin
        out_vld_q  <= push;
      end
    end else if (push) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || pop) begin
      if (skid_vld_q) begin
        out_q <= skid_q;
        if (push) begin
          skid_q <= res;
        end
      end else if (push) begin
        out_q <= res;
      end
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid entry valid with empty result register");

  a_disabled_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!enable_q && !cfg_wr) |=> ($stable(acc_q) && $stable(pend_q) && $stable(prev_q)))
    else $error("watch state moved while disabled");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push && !cfg_wr) |=> ($stable(ctime_q) && $stable(acc_q)))
    else $error("watch state moved without a transfer");

  a_full_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !out_ready_i) |=> (skid_vld_q && $stable(skid_q)))
    else $error("skid entry lost while receiver stalled");

endmodule

`default_nettype wire

FILE: tb/tb_gpio_watch_debouncer.sv
`default_nettype none

module tb_gpio_watch_debouncer;
  timeunit 1ns;
  timeprecision 1ps;

  import gwd_pkg::*;

  localparam logic [ModeWidth-1:0] MODE_SPARE_LO = 3'd5;
  localparam int unsigned PhaseCount = 10;
  localparam int unsigned PollsPerPhase = 95;

  class poll_scoreboard;
    logic                  enable;
    logic [ModeWidth-1:0]  mode;
    logic [DelayWidth-1:0] delay_ms;
    logic                  start_level;
    logic                  last_raw;
    logic                  level;
    logic [NowWidth-1:0]   change_at;
    logic                  change_open;
    out_item_t             awaited_results[$];
    int                    errors;

    function new();
      enable      = 1'b0;
      mode        = MODE_CHANGE;
      delay_ms    = '0;
      start_level = 1'b0;
      load_start();
      errors      = 0;
    endfunction

    function void load_start();
      last_raw    = start_level;
      level       = start_level;
      change_at   = '0;
      change_open = 1'b0;
    endfunction

    function void write_reg(reg_index_e idx, logic [DataWidth-1:0] val);
      case (idx)
        REG_ENABLE: begin
          enable = val[0];
        end
        REG_WATCH_MODE: begin
          mode = val[ModeWidth-1:0];
        end
        REG_SETTLE_DELAY: begin
          delay_ms = val[DelayWidth-1:0];
        end
        REG_START_LEVEL: begin
          start_level = val[0];
          load_start();
        end
        default: begin
        end
      endcase
    endfunction

    function out_item_t settle_poll(in_item_t p);
      out_item_t           r;
      logic [NowWidth-1:0] elapsed;
      r.fire = 1'b0;
      if (enable) begin
        if (last_raw != p.pin_level) begin
          change_at   = p.now_ms;
          change_open = 1'b1;
        end
        elapsed = p.now_ms - change_at;
        if ((mode == MODE_LOW_LEVEL && !p.pin_level) ||
            (mode == MODE_HIGH_LEVEL && p.pin_level)) begin
          r.fire = 1'b1;
        end else if (change_open && elapsed >= delay_ms) begin
          if (p.pin_level != level) begin
            level = p.pin_level;
            if (mode == MODE_CHANGE ||
                (mode == MODE_RISING && p.pin_level) ||
                (mode == MODE_FALLING && !p.pin_level)) begin
              r.fire = 1'b1;
            end
          end
          change_open = 1'b0;
        end
        last_raw = p.pin_level;
      end
      r.stable_level = level;
      return r;
    endfunction

    function void note_poll(in_item_t p);
      awaited_results.push_back(settle_poll(p));
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t exp;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result fire=%0b level=%0b", got.fire,
                         got.stable_level));
      end else begin
        exp = awaited_results.pop_front();
        if (got.fire !== exp.fire)
          report($sformatf("fire %0b, expected %0b", got.fire, exp.fire));
        if (got.stable_level !== exp.stable_level)
          report($sformatf("stable_level %0b, expected %0b", got.stable_level,
                           exp.stable_level));
      end
    endtask
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_item;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrWidth-1:0] paddr;
  logic [DataWidth-1:0] pwdata;
  logic [DataWidth-1:0] prdata;
  logic                 pready;

  poll_scoreboard       sb;
  int unsigned          send_idle_pct;
  int unsigned          recv_stall_pct;
  logic [NowWidth-1:0]  t_now;
  logic                 lvl;
  int unsigned          step_span;

  gpio_watch_debouncer DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  initial begin
    out_ready = 1'b0;
  end

  always @(negedge clk_i) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && out_ready) sb.check_result(out_item);
      if (in_valid && in_ready) sb.note_poll(in_item);
    end
  end

  task automatic send_poll(logic pin, logic [NowWidth-1:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid          <= 1'b1;
    in_item.pin_level <= pin;
    in_item.now_ms    <= now;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_index_e idx, logic [DataWidth-1:0] val);
    drain();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, val);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_phase(int unsigned n_polls);
    int unsigned pick;
    for (int unsigned i = 0; i < n_polls; i++) begin
      if ($urandom_range(99) < 25) lvl = ~lvl;
      pick = $urandom_range(99);
      if (pick < 10) begin
      end else if (pick < 60) begin
        t_now = t_now + $urandom_range(3, 1);
      end else if (pick < 92) begin
        t_now = t_now + $urandom_range(step_span + 2);
      end else begin
        t_now = $urandom();
      end
      send_poll(lvl, t_now);
    end
  endtask

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [DelayWidth-1:0] dly;
    sb             = new();
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    in_item        = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    send_idle_pct  = 31;
    recv_stall_pct = 47;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // watch still disabled out of reset
    send_poll(1'b1, 32'hFFFF_FFFF);
    apb_write(REG_ENABLE, 32'd1);
    apb_write(REG_WATCH_MODE, 32'(MODE_CHANGE));
    apb_write(REG_SETTLE_DELAY, 32'd0);
    apb_write(REG_START_LEVEL, 32'd0);
    send_poll(1'b1, 32'h0000_0000);
    send_poll(1'b0, 32'hFFFF_FFFF);
    apb_write(REG_SETTLE_DELAY, 32'd3);
    // elapsed time across the counter wrap
    send_poll(1'b1, 32'hFFFF_FFFE);
    send_poll(1'b1, 32'h0000_0001);
    // bounce that settles back on the accepted level
    send_poll(1'b0, 32'd10);
    send_poll(1'b1, 32'd11);
    send_poll(1'b1, 32'd14);
    apb_write(REG_WATCH_MODE, 32'(MODE_RISING));
    send_poll(1'b0, 32'd20);
    send_poll(1'b0, 32'd23);
    send_poll(1'b1, 32'd24);
    send_poll(1'b1, 32'd30);
    apb_write(REG_WATCH_MODE, 32'(MODE_FALLING));
    send_poll(1'b0, 32'd31);
    send_poll(1'b0, 32'd40);
    // level match skips the debounce, change stays open
    apb_write(REG_WATCH_MODE, 32'(MODE_HIGH_LEVEL));
    send_poll(1'b1, 32'd41);
    send_poll(1'b1, 32'd50);
    apb_write(REG_WATCH_MODE, 32'(MODE_LOW_LEVEL));
    send_poll(1'b1, 32'd60);
    send_poll(1'b0, 32'd61);
    apb_write(REG_WATCH_MODE, 32'(MODE_SPARE_LO));
    send_poll(1'b1, 32'd62);
    send_poll(1'b1, 32'd70);
    // delay at its maximum, beyond the elapsed times of these polls
    apb_write(REG_SETTLE_DELAY, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'd71);
    send_poll(1'b0, 32'h0000_0070);
    apb_write(REG_START_LEVEL, 32'd1);
    send_poll(1'b1, 32'hFFFF_FFFF);
    send_poll(1'b0, 32'h0000_0000);
    apb_write(REG_ENABLE, 32'd0);
    send_poll(1'b1, 32'h5555_5555);

    for (int unsigned k = 0; k < PhaseCount; k++) begin
      if (k < 4) begin
        send_idle_pct  = 31;
        recv_stall_pct = 47;
      end else if (k < 7) begin
        send_idle_pct  = 47;
        recv_stall_pct = 31;
      end else begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      case (k % 5)
        0:       dly = '0;
        1:       dly = $urandom_range(4, 1);
        2:       dly = $urandom_range(20, 5);
        3:       dly = 32'hFFFF_FFFF;
        default: dly = $urandom();
      endcase
      step_span = (dly <= 32) ? dly : 40;
      apb_write(REG_ENABLE, (k == 6) ? 32'd0 : 32'd1);
      apb_write(REG_WATCH_MODE, (k < 8) ? 32'(k % 8) : 32'($urandom_range(7)));
      apb_write(REG_SETTLE_DELAY, dly);
      if (k == 0 || $urandom_range(1)) begin
        lvl = 1'($urandom_range(1));
        apb_write(REG_START_LEVEL, 32'(lvl));
      end
      t_now = (k % 2 == 0) ? $urandom() : 32'hFFFF_FFF0 + $urandom_range(15);
      run_phase(PollsPerPhase);
    end

    drain();
    repeat (5) @(posedge clk_i);
    if (sb.awaited_results.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited_results.size()));
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: gpio_watch_debouncer.f
design/gwd_pkg.sv
design/gpio_watch_debouncer.sv
tb/tb_gpio_watch_debouncer.sv
